// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PWLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define PWLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/pwle_pkg.sv -----
// Types and constants of the pulse width byte line encoder.
`default_nettype none

package pwle_pkg;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_DATA   = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [2:0] CFG_START_SCANS   = 3'd0;
    localparam logic [2:0] CFG_ONE_SCANS     = 3'd1;
    localparam logic [2:0] CFG_ZERO_SCANS    = 3'd2;
    localparam logic [2:0] CFG_START_WAKEUPS = 3'd3;
    localparam logic [2:0] CFG_INTER_WAKEUPS = 3'd4;

    localparam logic [3:0] MAX_WAKE = 4'd8;
    localparam logic [8:0] SUM_MULT = 9'h17b;
    localparam int         SUM_SHIFT = 11;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] start_scans;
        logic [7:0] one_scans;
        logic [7:0] zero_scans;
        logic [3:0] start_wakeups;
        logic [3:0] inter_wakeups;
    } t_cfg;

    typedef struct packed {
        logic       err;
        logic [3:0] wakeups;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WAKE_START,
        S_BITS,
        S_WAKE_INTER
    } t_seq_state;

    function automatic logic [3:0] clamp_wake(input logic [3:0] n);
        return (n > MAX_WAKE) ? MAX_WAKE : n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pulse_width_byte_line_encoder.sv -----
// Top level of the pulse width byte line encoder: configuration and wiring.
//
// Usage: items enter on the s_ stream, tuser = action (0 start with payload
// length in tdata, 1 payload byte in tdata, 2 finish with checksum, 3 ignored).
// Each item's pulses leave on the m_ stream, one per transfer: tdata = pulse
// width in scans, tlast marks the final pulse of an item, tuser flags an
// error (width 0, single pulse). Pulse widths and wake-up counts are to be
// written through the cfg port only while the block is idle; the block itself
// does not enforce this. The first pulse of an item passes the command queue,
// the sequencer state and the output register; an error pulse passes the
// queue and the output register. Throughput: the sequencer sends one pulse
// per cycle while the receiver takes them, and takes a command only in its
// idle state, after the last pulse of the previous one. The front end accepts
// one item per cycle until the four-entry command queue is full.
// Reset clears the checksum, closes any message, empties the queue and loads
// the default widths and counts. When the receiver stalls the output register
// holds its pulse, the sequencer waits, and input stalls once the queue fills.
`default_nettype none

module pulse_width_byte_line_encoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  wire logic [1:0] i_s_tuser,   // [1:0] action
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] pulse_scans
    output logic            o_m_tlast,
    output logic            o_m_tuser,   // [0] error
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    pwle_pkg::t_cfg r_cfg;
    pwle_pkg::t_cmd push_cmd;
    pwle_pkg::t_cmd head_cmd;
    logic           push;
    logic           pop;
    logic           q_valid;
    logic           q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_scans   <= 8'd3;
            r_cfg.one_scans     <= 8'd12;
            r_cfg.zero_scans    <= 8'd8;
            r_cfg.start_wakeups <= 4'd4;
            r_cfg.inter_wakeups <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pwle_pkg::CFG_START_SCANS:   r_cfg.start_scans   <= i_cfg_data;
                pwle_pkg::CFG_ONE_SCANS:     r_cfg.one_scans     <= i_cfg_data;
                pwle_pkg::CFG_ZERO_SCANS:    r_cfg.zero_scans    <= i_cfg_data;
                pwle_pkg::CFG_START_WAKEUPS: r_cfg.start_wakeups <= i_cfg_data[3:0];
                pwle_pkg::CFG_INTER_WAKEUPS: r_cfg.inter_wakeups <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    pwle_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tuser       (i_s_tuser),
        .i_start_wakeups (r_cfg.start_wakeups),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    pwle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    pwle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- rtl/pwle_front.sv -----
// Front end: accepts items, tracks message state and checksum, issues commands.
`default_nettype none

`include "assert_macros.svh"

module pwle_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [7:0]         i_s_tdata,
    input  wire logic [1:0]         i_s_tuser,
    input  wire logic [3:0]         i_start_wakeups,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output pwle_pkg::t_cmd          o_cmd
);

    logic [31:0] r_sum;
    logic [31:0] n_sum;
    logic [8:0]  r_left;
    logic [8:0]  n_left;
    logic        accept;
    logic [31:0] base;
    logic [7:0]  byte_in;
    logic [31:0] prod;
    logic [31:0] next_sum;
    logic        upd_sum;
    pwle_pkg::t_action act;

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign act        = pwle_pkg::t_action'(i_s_tuser);

    assign prod     = 32'(base * pwle_pkg::SUM_MULT);
    assign next_sum = prod + {24'd0, byte_in} + 32'($signed(base) >>> pwle_pkg::SUM_SHIFT);

    always_comb begin
        base        = r_sum;
        byte_in     = i_s_tdata;
        upd_sum     = 1'b0;
        n_left      = r_left;
        o_push      = 1'b0;
        o_cmd.err   = 1'b0;
        o_cmd.wakeups = 4'd0;
        o_cmd.data  = i_s_tdata;
        unique case (act)
            pwle_pkg::ACT_START: begin
                base          = 32'd0;
                byte_in       = i_s_tdata + 8'd2;
                upd_sum       = 1'b1;
                n_left        = {1'b0, i_s_tdata} + 9'd1;
                o_push        = 1'b1;
                o_cmd.wakeups = pwle_pkg::clamp_wake(i_start_wakeups);
                o_cmd.data    = byte_in;
            end
            pwle_pkg::ACT_DATA: begin
                o_push = 1'b1;
                if (r_left <= 9'd1) begin
                    o_cmd.err = 1'b1;
                end else begin
                    upd_sum = 1'b1;
                    n_left  = r_left - 9'd1;
                end
            end
            pwle_pkg::ACT_FINISH: begin
                o_push = 1'b1;
                if (r_left == 9'd0) begin
                    o_cmd.err = 1'b1;
                end else begin
                    byte_in    = r_sum[7:0];
                    o_cmd.data = r_sum[7:0];
                    upd_sum    = 1'b1;
                    n_left     = 9'd0;
                end
            end
            pwle_pkg::ACT_NONE: begin
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        if (!accept) begin
            o_push  = 1'b0;
            upd_sum = 1'b0;
            n_left  = r_left;
        end
        n_sum = upd_sum ? next_sum : r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= 32'd0;
            r_left <= 9'd0;
        end else begin
            r_sum  <= n_sum;
            r_left <= n_left;
        end
    end

    `PWLE_ASSERT_NXT(a_err_keeps_state, i_clk, i_rst_n, o_push && o_cmd.err,
        $stable(r_left) && $stable(r_sum))
    `PWLE_ASSERT_IMP(a_push_has_room, i_clk, i_rst_n, o_push, !i_q_full)

endmodule

`default_nettype wire

// ----- rtl/pwle_queue.sv -----
// Command queue between the front end and the pulse sequencer.
`default_nettype none

`include "assert_macros.svh"

module pwle_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pwle_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output pwle_pkg::t_cmd      o_cmd,
    output logic                o_valid,
    output logic                o_full
);

    pwle_pkg::t_cmd          r_mem [pwle_pkg::QDEPTH];
    logic [pwle_pkg::QAW-1:0] r_wr;
    logic [pwle_pkg::QAW-1:0] r_rd;
    logic [pwle_pkg::QAW:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (pwle_pkg::QAW+1)'(pwle_pkg::QDEPTH));
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + (pwle_pkg::QAW)'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + (pwle_pkg::QAW)'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (pwle_pkg::QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (pwle_pkg::QAW+1)'(1);
            end
        end
    end

    `PWLE_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_valid)
    `PWLE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= (pwle_pkg::QAW+1)'(pwle_pkg::QDEPTH))

endmodule

`default_nettype wire

// ----- rtl/pwle_back.sv -----
// Pulse sequencer: expands commands into wake-up and bit pulses, or a single error pulse.
`default_nettype none

`include "assert_macros.svh"

module pwle_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pwle_pkg::t_cfg i_cfg,
    input  wire pwle_pkg::t_cmd i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_pop,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [7:0]          o_m_tdata,
    output logic                o_m_tlast,
    output logic                o_m_tuser
);

    pwle_pkg::t_seq_state r_state;
    pwle_pkg::t_seq_state n_state;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;
    logic [3:0] r_sw;
    logic [3:0] n_sw;
    logic [7:0] r_data;
    logic [7:0] n_data;
    logic [3:0] iw;
    logic [3:0] cnt_inc;
    logic       emit_ok;
    logic       take;
    logic       emit;
    logic [7:0] e_scans;
    logic       e_last;
    logic       e_err;
    logic       r_out_valid;
    logic [7:0] r_out_scans;
    logic       r_out_last;
    logic       r_out_err;

    assign iw      = pwle_pkg::clamp_wake(i_cfg.inter_wakeups);
    assign cnt_inc = r_cnt + 4'd1;
    assign emit_ok = !r_out_valid || i_m_tready;
    assign take    = emit_ok && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sw    = r_sw;
        n_data  = r_data;
        unique case (r_state)
            pwle_pkg::S_IDLE: begin
                if (take && !i_cmd.err) begin
                    n_sw    = i_cmd.wakeups;
                    n_data  = i_cmd.data;
                    n_cnt   = 4'd0;
                    n_state = (i_cmd.wakeups != 4'd0) ? pwle_pkg::S_WAKE_START
                                                     : pwle_pkg::S_BITS;
                end
            end
            pwle_pkg::S_WAKE_START: begin
                if (emit_ok) begin
                    if (cnt_inc == r_sw) begin
                        n_cnt   = 4'd0;
                        n_state = pwle_pkg::S_BITS;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            pwle_pkg::S_BITS: begin
                if (emit_ok) begin
                    if (r_cnt == 4'd7) begin
                        n_cnt   = 4'd0;
                        n_state = (iw != 4'd0) ? pwle_pkg::S_WAKE_INTER : pwle_pkg::S_IDLE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            pwle_pkg::S_WAKE_INTER: begin
                if (emit_ok) begin
                    if (cnt_inc == iw) begin
                        n_cnt   = 4'd0;
                        n_state = pwle_pkg::S_IDLE;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            default: begin
                n_state = pwle_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        e_scans   = i_cfg.start_scans;
        e_last    = 1'b0;
        e_err     = 1'b0;
        unique case (r_state)
            pwle_pkg::S_IDLE: begin
                o_cmd_pop = take;
                emit      = take && i_cmd.err;
                e_scans   = 8'd0;
                e_last    = 1'b1;
                e_err     = 1'b1;
            end
            pwle_pkg::S_WAKE_START: begin
                emit = emit_ok;
            end
            pwle_pkg::S_BITS: begin
                emit    = emit_ok;
                e_scans = r_data[r_cnt[2:0]] ? i_cfg.one_scans : i_cfg.zero_scans;
                e_last  = (r_cnt == 4'd7) && (iw == 4'd0);
            end
            pwle_pkg::S_WAKE_INTER: begin
                emit   = emit_ok;
                e_last = (cnt_inc == iw);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwle_pkg::S_IDLE;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sw   <= n_sw;
        r_data <= n_data;
        if (emit) begin
            r_out_scans <= e_scans;
            r_out_last  <= e_last;
            r_out_err   <= e_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_scans;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_err;

    `PWLE_ASSERT_IMP(a_err_shape, i_clk, i_rst_n, r_out_valid && r_out_err,
        r_out_last && (r_out_scans == 8'd0))
    `PWLE_ASSERT_IMP(a_pop_only_idle, i_clk, i_rst_n, o_cmd_pop,
        (r_state == pwle_pkg::S_IDLE) && emit_ok)
    `PWLE_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !i_m_tready,
        r_out_valid && $stable(r_out_scans) && $stable(r_out_last))

endmodule

`default_nettype wire

// ----- tb/pulse_width_byte_line_encoder_test.sv -----
// Self-checking testbench of the pulse width byte line encoder: predicted pulses vs. stream.
`default_nettype none

module pulse_width_byte_line_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 12;

    typedef struct packed {
        logic [7:0] scans;
        logic       last;
        logic       err;
    } t_pulse;

    typedef enum {ROW_PREDICT, ROW_ERROR, ROW_SILENT} t_row;

    typedef struct {
        pwle_pkg::t_action act;
        logic [7:0]        data;
        t_row              kind;
    } t_stim;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_s_tvalid;
    logic       o_s_tready;
    logic [7:0] i_s_tdata;   // [7:0] data_byte
    logic [1:0] i_s_tuser;   // [1:0] action
    logic       o_m_tvalid;
    logic       i_m_tready;
    logic [7:0] o_m_tdata;   // [7:0] pulse_scans
    logic       o_m_tlast;
    logic       o_m_tuser;   // [0] error
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    pulse_width_byte_line_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Line encoder state kept alongside the block.
    logic [7:0]  width_wake;
    logic [7:0]  width_one;
    logic [7:0]  width_zero;
    logic [3:0]  wake_count_start;
    logic [3:0]  wake_count_inter;
    logic [31:0] line_checksum;
    logic [8:0]  payload_left;

    t_pulse expected_pulses[$];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int items_sent    = 0;
    int mismatches    = 0;

    t_stim directed[23] = '{
        '{pwle_pkg::ACT_DATA,   8'h5a, ROW_ERROR},
        '{pwle_pkg::ACT_FINISH, 8'hff, ROW_ERROR},
        '{pwle_pkg::ACT_NONE,   8'hff, ROW_SILENT},
        '{pwle_pkg::ACT_START,  8'h00, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'hff, ROW_ERROR},
        '{pwle_pkg::ACT_FINISH, 8'h00, ROW_PREDICT},
        '{pwle_pkg::ACT_FINISH, 8'h00, ROW_ERROR},
        '{pwle_pkg::ACT_START,  8'hff, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'h00, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'hff, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'ha5, ROW_PREDICT},
        '{pwle_pkg::ACT_NONE,   8'h00, ROW_SILENT},
        '{pwle_pkg::ACT_DATA,   8'h5a, ROW_PREDICT},
        '{pwle_pkg::ACT_START,  8'h02, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'h81, ROW_PREDICT},
        '{pwle_pkg::ACT_FINISH, 8'h55, ROW_PREDICT},
        '{pwle_pkg::ACT_START,  8'hfe, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'h7e, ROW_PREDICT},
        '{pwle_pkg::ACT_FINISH, 8'haa, ROW_PREDICT},
        '{pwle_pkg::ACT_START,  8'h01, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'h01, ROW_PREDICT},
        '{pwle_pkg::ACT_DATA,   8'h80, ROW_ERROR},
        '{pwle_pkg::ACT_FINISH, 8'h00, ROW_PREDICT}
    };

    function automatic logic [31:0] checksum_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] shifted;
        shifted = {{11{c[31]}}, c[31:11]};
        return 32'h17b * c + {24'd0, b} + shifted;
    endfunction

    task automatic push_pulse(input logic [7:0] scans, input logic err);
        t_pulse p;
        p.scans = scans;
        p.last  = 1'b0;
        p.err   = err;
        expected_pulses.push_back(p);
    endtask

    task automatic push_wakeups(input logic [3:0] count);
        int n;
        n = (count > 4'd8) ? 8 : int'(count);
        repeat (n) push_pulse(width_wake, 1'b0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        line_checksum = checksum_next(line_checksum, b);
        for (int i = 0; i < 8; i++) begin
            push_pulse(b[i] ? width_one : width_zero, 1'b0);
        end
        push_wakeups(wake_count_inter);
    endtask

    task automatic predict_pulses(input pwle_pkg::t_action act, input logic [7:0] b);
        int first;
        first = expected_pulses.size();
        case (act)
            pwle_pkg::ACT_START: begin
                line_checksum = 32'd0;
                payload_left  = {1'b0, b} + 9'd1;
                push_wakeups(wake_count_start);
                push_byte(b + 8'd2);
            end
            pwle_pkg::ACT_DATA: begin
                if (payload_left <= 9'd1) begin
                    push_pulse(8'd0, 1'b1);
                end else begin
                    payload_left = payload_left - 9'd1;
                    push_byte(b);
                end
            end
            pwle_pkg::ACT_FINISH: begin
                if (payload_left == 9'd0) begin
                    push_pulse(8'd0, 1'b1);
                end else begin
                    push_byte(line_checksum[7:0]);
                    payload_left = 9'd0;
                end
            end
            default: ;
        endcase
        if (expected_pulses.size() > first)
            expected_pulses[expected_pulses.size() - 1].last = 1'b1;
    endtask

    task automatic write_config(input logic [7:0] wake_w, input logic [7:0] one_w,
                                input logic [7:0] zero_w, input logic [3:0] start_n,
                                input logic [3:0] inter_n);
        logic [7:0] vals[5];
        logic [2:0] idxs[5];
        vals = '{wake_w, one_w, zero_w, {4'd0, start_n}, {4'd0, inter_n}};
        idxs = '{pwle_pkg::CFG_START_SCANS, pwle_pkg::CFG_ONE_SCANS,
                 pwle_pkg::CFG_ZERO_SCANS, pwle_pkg::CFG_START_WAKEUPS,
                 pwle_pkg::CFG_INTER_WAKEUPS};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        width_wake       = wake_w;
        width_one        = one_w;
        width_zero       = zero_w;
        wake_count_start = start_n;
        wake_count_inter = inter_n;
    endtask

    task automatic send_item(input pwle_pkg::t_action act, input logic [7:0] b,
                             input t_row kind);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        case (kind)
            ROW_PREDICT: predict_pulses(act, b);
            ROW_ERROR:   expected_pulses.push_back('{8'd0, 1'b1, 1'b1});
            default: ;
        endcase
        if (act != pwle_pkg::ACT_NONE) items_sent++;
    endtask

    // Drop valid, wait for all pulses, then let any silent items retire.
    task automatic drain_line();
        i_s_tvalid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_messages(input int count);
        int stop;
        int len;
        int nbytes;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(99) < 85) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
                send_item(pwle_pkg::ACT_START, 8'(len), ROW_PREDICT);
                nbytes = (len > 8) ? $urandom_range(8) : len;
                case ($urandom_range(9))
                    0: nbytes += $urandom_range(2, 1);
                    1: nbytes = $urandom_range(nbytes);
                    default: ;
                endcase
                for (int k = 0; k < nbytes; k++)
                    send_item(pwle_pkg::ACT_DATA, 8'($urandom_range(255)), ROW_PREDICT);
                if ($urandom_range(9) != 0)
                    send_item(pwle_pkg::ACT_FINISH, 8'($urandom_range(255)), ROW_PREDICT);
            end else begin
                send_item(pwle_pkg::t_action'($urandom_range(3)),
                          8'($urandom_range(255)), ROW_PREDICT);
            end
        end
    endtask

    // Pulse receiver: check each transfer, then pick tready for the next cycle.
    initial begin
        int hold_left;
        int holds_done;
        t_pulse got;
        t_pulse want;
        hold_left  = 0;
        holds_done = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.scans = o_m_tdata;
                got.last  = o_m_tlast;
                got.err   = o_m_tuser;
                if (expected_pulses.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no pulse, got scans=%0d last=%0b err=%0b",
                             $time, got.scans, got.last, got.err);
                end else begin
                    want = expected_pulses.pop_front();
                    if (got.scans !== want.scans || got.last !== want.last ||
                        got.err !== want.err) begin
                        mismatches++;
                        $display({"%0t: expected scans=%0d last=%0b err=%0b, ",
                                  "got scans=%0d last=%0b err=%0b"},
                                 $time, want.scans, want.last, want.err,
                                 got.scans, got.last, got.err);
                    end
                end
            end
            if (holds_done != hold_requests) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'd0;
        i_s_tuser  <= pwle_pkg::ACT_NONE;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= pwle_pkg::CFG_START_SCANS;
        i_cfg_data <= 8'd0;
        width_wake       = 8'd3;
        width_one        = 8'd12;
        width_zero       = 8'd8;
        wake_count_start = 4'd4;
        wake_count_inter = 4'd1;
        line_checksum    = 32'd0;
        payload_left     = 9'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_item(directed[i].act, directed[i].data, directed[i].kind);
        drain_line();

        write_config(8'd255, 8'd255, 8'd0, 4'd15, 4'd0);
        send_messages(45);
        drain_line();

        write_config(8'd1, 8'd1, 8'd255, 4'd0, 4'd8);
        tx_idle_pct = 71;
        send_messages(45);
        drain_line();

        // Hold off the receiver long enough for the input side to back up.
        write_config(8'd0, 8'd0, 8'd1, 4'd8, 4'd15);
        tx_idle_pct  = 0;
        rx_stall_pct = 71;
        hold_requests++;
        send_messages(45);
        drain_line();

        write_config(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
        tx_idle_pct  = 32;
        rx_stall_pct = 32;
        send_messages(45);
        drain_line();

        write_config(8'd3, 8'd12, 8'd8, 4'd4, 4'd1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_messages(45);
        drain_line();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- pulse_width_byte_line_encoder.f -----
+incdir+rtl
rtl/pwle_pkg.sv
rtl/pwle_front.sv
rtl/pwle_queue.sv
rtl/pwle_back.sv
rtl/pulse_width_byte_line_encoder.sv
tb/pulse_width_byte_line_encoder_test.sv
